>>> rtl/core/ggdfs_pkg.sv
// Package for the grid graph depth-first path finder.
// Holds grid constants, command codes and the item structs; no dependencies.
package ggdfs_pkg;
	localparam int ROWS = 16;
	localparam int COLS = 16;
	localparam int STACK_DEPTH = 1024;
	localparam int NODES = ROWS * COLS;
	localparam int PATH_DEPTH = 256;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] node;
		logic link_down;
		logic link_right;
		logic [7:0] start_node;
		logic [7:0] target_node;
		logic [7:0] path_pos;
	} in_item_t;

	typedef struct packed {
		logic reached;
		logic [8:0] path_count;
		logic [7:0] path_node;
		logic stack_overflow;
	} out_item_t;
endpackage

>>> rtl/core/ggdfs_front.sv
// Front end: input item register and a two-entry command queue.
// Depends on ggdfs_pkg.
module ggdfs_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input ggdfs_pkg::in_item_t in_item,
	output logic cmd_valid,
	output ggdfs_pkg::in_item_t cmd_item,
	input logic cmd_take
);
	import ggdfs_pkg::*;

	in_item_t buf_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd_item = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) buf_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (cmd_take && cmd_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take && cmd_valid);
		end
	end
endmodule

>>> rtl/core/ggdfs_back.sv
// Back end: link maps, search sequencer, stack, parent and path memories.
// Depends on ggdfs_pkg.
module ggdfs_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input ggdfs_pkg::in_item_t cmd_item,
	output logic cmd_take,
	output logic empty,
	input logic pop,
	output ggdfs_pkg::out_item_t out_item
);
	import ggdfs_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_CLR = 4'd1, ST_POPA = 4'd2,
		ST_POPB = 4'd3, ST_EXP = 4'd4, ST_WALK = 4'd5, ST_WALKB = 4'd6,
		ST_READ = 4'd7, ST_OUT = 4'd8, ST_INIT = 4'd9, ST_EXPB = 4'd10;

	logic [3:0] st_q;
	logic [1:0] link_mem [NODES];
	logic vis_mem [NODES];
	logic [8:0] par_mem [NODES];
	logic [7:0] stk_mem [STACK_DEPTH];
	logic [7:0] path_mem [PATH_DEPTH];
	logic [SPW-1:0] sp_q;
	logic [8:0] len_q;
	logic found_q, ovf_q;
	logic [7:0] tgt_q, cur_q, walk_q, pos_q, clr_q;
	logic [1:0] dir_q;
	logic [1:0] link_rd_q;
	logic vis_rd_q;
	logic [7:0] stk_rd_q, path_rd_q;
	logic [8:0] par_rd_q;
	logic [8:0] k_q;
	logic stk_full;
	logic [7:0] pnode_q;

	logic [7:0] row, col, nb, la;
	logic edge_ok;
	always_comb begin
		row = cur_q / 8'(COLS);
		col = cur_q % 8'(COLS);
		edge_ok = 1'b0;
		nb = cur_q;
		case (dir_q)
			2'd0: begin
				nb = cur_q + 8'(COLS);
				edge_ok = (32'(row) + 1 < ROWS) && link_rd_q[1];
			end
			2'd1: begin
				nb = cur_q + 8'd1;
				edge_ok = (32'(col) + 1 < COLS) && link_rd_q[0];
			end
			2'd2: begin
				nb = cur_q - 8'(COLS);
				edge_ok = (row != 8'd0) && link_rd_q[1];
			end
			default: begin
				nb = cur_q - 8'd1;
				edge_ok = (col != 8'd0) && link_rd_q[0];
			end
		endcase
		la = dir_q[1] ? nb : cur_q;
	end

	logic do_push;
	assign do_push = st_q == ST_EXPB && edge_ok && !vis_rd_q;
	assign cmd_take = st_q == ST_IDLE && cmd_valid;
	assign empty = st_q != ST_OUT;
	assign out_item = '{reached: found_q, path_count: len_q, path_node: pnode_q,
		stack_overflow: ovf_q};

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[sp_q[SAW-1:0] - SAW'(1)];
		par_rd_q <= par_mem[walk_q];
		path_rd_q <= path_mem[pos_q];
		link_rd_q <= link_mem[la];
		vis_rd_q <= vis_mem[nb];
		if (st_q == ST_INIT) link_mem[clr_q] <= 2'b00;
		if (cmd_take && cmd_item.command == CMD_LOAD && 32'(cmd_item.node) < NODES)
			link_mem[cmd_item.node] <= {cmd_item.link_down, cmd_item.link_right};
		if (st_q == ST_CLR) vis_mem[clr_q] <= 1'b0;
		if (st_q == ST_POPB) vis_mem[stk_rd_q] <= 1'b1;
		if (do_push && !stk_full) begin
			stk_mem[sp_q[SAW-1:0]] <= nb;
			par_mem[nb] <= {1'b0, cur_q};
		end
		if (cmd_take && cmd_item.command == CMD_SEARCH) begin
			par_mem[cmd_item.start_node] <= 9'h100;
			stk_mem[0] <= cmd_item.start_node;
		end
		if (st_q == ST_WALKB && k_q < 9'(PATH_DEPTH)) path_mem[k_q[7:0]] <= walk_q;
	end

	assign stk_full = sp_q >= SPW'(STACK_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
			sp_q <= '0;
			len_q <= '0;
			found_q <= 1'b0;
			ovf_q <= 1'b0;
			tgt_q <= '0; cur_q <= '0; walk_q <= '0; pos_q <= '0; clr_q <= '0;
			dir_q <= '0; k_q <= '0; pnode_q <= '0;
		end else begin
			case (st_q)
				ST_INIT: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'(NODES - 1)) begin
						clr_q <= '0;
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (cmd_valid) begin
					pnode_q <= '0;
					case (cmd_item.command)
						CMD_LOAD: st_q <= ST_OUT;
						CMD_SEARCH: begin
							found_q <= 1'b0;
							ovf_q <= 1'b0;
							len_q <= '0;
							tgt_q <= cmd_item.target_node;
							if (32'(cmd_item.start_node) >= NODES ||
								32'(cmd_item.target_node) >= NODES) begin
								sp_q <= '0;
								st_q <= ST_OUT;
							end else begin
								sp_q <= SPW'(1);
								clr_q <= '0;
								st_q <= ST_CLR;
							end
						end
						CMD_READ: begin
							pos_q <= cmd_item.path_pos;
							st_q <= (9'(cmd_item.path_pos) < len_q) ? ST_READ : ST_OUT;
						end
						default: st_q <= ST_OUT;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'(NODES - 1)) begin
						clr_q <= '0;
						st_q <= ST_POPA;
					end
				end
				ST_POPA: begin
					if (sp_q == '0) st_q <= ST_OUT;
					else st_q <= ST_POPB;
				end
				ST_POPB: begin
					cur_q <= stk_rd_q;
					sp_q <= sp_q - SPW'(1);
					dir_q <= 2'd0;
					if (stk_rd_q == tgt_q) begin
						walk_q <= stk_rd_q;
						k_q <= '0;
						st_q <= ST_WALK;
					end else st_q <= ST_EXP;
				end
				ST_EXP: st_q <= ST_EXPB;
				ST_EXPB: begin
					if (do_push && stk_full) begin
						ovf_q <= 1'b1;
						sp_q <= '0;
						st_q <= ST_OUT;
					end else begin
						if (do_push) sp_q <= sp_q + SPW'(1);
						dir_q <= dir_q + 2'd1;
						if (dir_q == 2'd3) st_q <= ST_POPA;
						else st_q <= ST_EXP;
					end
				end
				ST_WALK: st_q <= ST_WALKB;
				ST_WALKB: begin
					k_q <= k_q + 9'd1;
					if (par_rd_q[8] || 32'(k_q) + 1 >= NODES) begin
						len_q <= k_q + 9'd1;
						found_q <= 1'b1;
						sp_q <= '0;
						st_q <= ST_OUT;
					end else begin
						walk_q <= par_rd_q[7:0];
						st_q <= ST_WALK;
					end
				end
				ST_READ: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q[0]) begin
						pnode_q <= path_rd_q;
						clr_q <= '0;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: if (pop) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/grid_graph_dfs_path_finder_unit.sv
// Top level of the grid graph depth-first path finder.
// Load items and reads beyond the path go straight to the result; path reads first fetch
// the node from the path memory. A search clears the visited map, then pops nodes and
// expands each in its four directions; when the target is popped it walks the parent chain
// into the path memory. One item is in the back end at a time; the front queue holds two
// more. Reset is asynchronous; a pass then clears the link maps before any item is taken.
module grid_graph_dfs_path_finder_unit (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input ggdfs_pkg::in_item_t in_item,
	output logic empty,
	input logic pop,
	output ggdfs_pkg::out_item_t out_item
);
	import ggdfs_pkg::*;

	logic cmd_valid, cmd_take;
	in_item_t cmd_item;

	ggdfs_front u_front (.clk, .arst_n, .push, .full, .in_item,
		.cmd_valid, .cmd_item, .cmd_take);
	ggdfs_back u_back (.clk, .arst_n, .cmd_valid, .cmd_item, .cmd_take,
		.empty, .pop, .out_item);

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.reached |-> out_item.path_count != 9'd0) else $error("len");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(out_item.reached && out_item.stack_overflow)) else $error("flags");
	a_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.stack_overflow |-> out_item.path_count == 9'd0)
		else $error("ovf");
endmodule

>>> dv/tb_top.sv
// Testbench for the grid graph depth-first path finder unit.
// Drives load, search and read items through the push/full queue and checks every result
// against a built-in model of the search; depends on ggdfs_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_top;
	import ggdfs_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	in_item_t in_item = '0;
	out_item_t out_item;

	grid_graph_dfs_path_finder_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.in_item(in_item), .empty(empty), .pop(pop), .out_item(out_item)
	);

	always #5 clk = ~clk;

	in_item_t pending_items[$];
	out_item_t expected_status[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_sender = 1'b0;
	bit took_item = 1'b0;

	bit grid_down[NODES];
	bit grid_right[NODES];
	bit seen_map[NODES];
	logic [8:0] parent_of[NODES];
	logic [7:0] dfs_stack[STACK_DEPTH];
	logic [7:0] route_store[PATH_DEPTH];
	int route_len = 0;
	bit route_found = 1'b0;
	bit stack_full_flag = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic in_item_t random_item();
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		return noise[$bits(in_item_t)-1:0];
	endfunction

	function automatic bit try_push(input int nb, input int cur, inout int sp);
		if (seen_map[nb])
			return 1'b1;
		parent_of[nb] = 9'(cur);
		if (sp >= STACK_DEPTH)
			return 1'b0;
		dfs_stack[sp] = 8'(nb);
		sp++;
		return 1'b1;
	endfunction

	function automatic void search_grid(input int start, input int target);
		int sp;
		int cur;
		int walk;
		int k;
		bit ok;
		route_found = 1'b0;
		stack_full_flag = 1'b0;
		route_len = 0;
		if (start >= NODES || target >= NODES)
			return;
		foreach (seen_map[i])
			seen_map[i] = 1'b0;
		parent_of[start] = 9'h100;
		dfs_stack[0] = 8'(start);
		sp = 1;
		while (sp > 0) begin
			sp--;
			cur = int'(dfs_stack[sp]);
			seen_map[cur] = 1'b1;
			if (cur == target) begin
				walk = cur;
				k = 0;
				forever begin
					if (k < PATH_DEPTH)
						route_store[k] = 8'(walk);
					k++;
					if (parent_of[walk][8] || k >= NODES)
						break;
					walk = int'(parent_of[walk][7:0]);
				end
				route_len = k;
				route_found = 1'b1;
				return;
			end
			ok = 1'b1;
			if (ok && cur / COLS + 1 < ROWS && grid_down[cur])
				ok = try_push(cur + COLS, cur, sp);
			if (ok && cur % COLS + 1 < COLS && grid_right[cur])
				ok = try_push(cur + 1, cur, sp);
			if (ok && cur / COLS > 0 && grid_down[cur - COLS])
				ok = try_push(cur - COLS, cur, sp);
			if (ok && cur % COLS > 0 && grid_right[cur - 1])
				ok = try_push(cur - 1, cur, sp);
			if (!ok) begin
				stack_full_flag = 1'b1;
				return;
			end
		end
	endfunction

	function automatic out_item_t predict_status(input in_item_t it);
		out_item_t r;
		r = '0;
		case (it.command)
			CMD_LOAD: begin
				if (it.node < NODES) begin
					grid_down[it.node] = it.link_down;
					grid_right[it.node] = it.link_right;
				end
			end
			CMD_SEARCH: begin
				search_grid(int'(it.start_node), int'(it.target_node));
			end
			CMD_READ: begin
				if (it.path_pos < route_len)
					r.path_node = route_store[it.path_pos];
			end
			default: begin
			end
		endcase
		r.reached = route_found;
		r.path_count = 9'(route_len);
		r.stack_overflow = stack_full_flag;
		return r;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (took_item || !push) begin
				if (pending_items.size() > 0 && !hold_sender
						&& $urandom_range(99) >= send_idle_pct) begin
					in_item <= pending_items[0];
					push <= 1'b1;
				end else begin
					push <= 1'b0;
					in_item <= random_item();
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		took_item = 1'b0;
		if (push && !full) begin
			expected_status.insert(expected_status.size(),
				predict_status(pending_items.pop_front()));
			took_item = 1'b1;
		end
		if (pop && !empty) begin
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected item", 0, 0);
			end else begin
				want = expected_status.pop_front();
				if (out_item.reached !== want.reached)
					report_mismatch("reached", out_item.reached, want.reached);
				if (out_item.path_count !== want.path_count)
					report_mismatch("path_count", out_item.path_count, want.path_count);
				if (out_item.path_node !== want.path_node)
					report_mismatch("path_node", out_item.path_node, want.path_node);
				if (out_item.stack_overflow !== want.stack_overflow)
					report_mismatch("stack_overflow", out_item.stack_overflow,
						want.stack_overflow);
			end
		end
	end

	function automatic in_item_t make_item(input logic [1:0] cmd, input int a, input int b,
			input int c, input int d);
		in_item_t it;
		it = random_item();
		it.command = cmd;
		case (cmd)
			CMD_LOAD: begin
				it.node = 8'(a);
				it.link_down = b[0];
				it.link_right = c[0];
			end
			CMD_SEARCH: begin
				it.start_node = 8'(a);
				it.target_node = 8'(b);
			end
			CMD_READ: it.path_pos = 8'(a);
			default: begin
			end
		endcase
		return it;
	endfunction

	task automatic add_item(input in_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_status.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_random(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 50)
				add_item(make_item(CMD_LOAD, $urandom_range(255),
					int'($urandom_range(99) < 75), int'($urandom_range(99) < 75), 0));
			else if (r < 70)
				add_item(make_item(CMD_SEARCH,
					($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(31),
					($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(255), 0, 0));
			else if (r < 95)
				add_item(make_item(CMD_READ,
					($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40), 0, 0, 0));
			else
				add_item(make_item(2'd3, 0, 0, 0, 0));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_item(make_item(CMD_SEARCH, 0, 0, 0, 0));
		add_item(make_item(CMD_READ, 0, 0, 0, 0));
		add_item(make_item(CMD_READ, 1, 0, 0, 0));
		add_item(make_item(CMD_SEARCH, 0, 255, 0, 0));
		add_item(make_item(CMD_LOAD, 0, 1, 1, 0));
		add_item(make_item(CMD_LOAD, 1, 1, 0, 0));
		add_item(make_item(CMD_LOAD, 17, 0, 1, 0));
		add_item(make_item(CMD_LOAD, 15, 1, 1, 0));
		add_item(make_item(CMD_LOAD, 255, 1, 1, 0));
		add_item(make_item(CMD_LOAD, 240, 1, 1, 0));
		add_item(make_item(CMD_SEARCH, 0, 18, 0, 0));
		add_item(make_item(CMD_READ, 0, 0, 0, 0));
		add_item(make_item(CMD_READ, 3, 0, 0, 0));
		add_item(make_item(CMD_READ, 255, 0, 0, 0));
		add_item(make_item(CMD_SEARCH, 18, 0, 0, 0));
		add_item(make_item(CMD_READ, 2, 0, 0, 0));
		add_item(make_item(CMD_SEARCH, 15, 16, 0, 0));
		add_item(make_item(CMD_SEARCH, 255, 240, 0, 0));
		add_item(make_item(2'd3, 0, 0, 0, 0));
		add_item(make_item(CMD_SEARCH, 5, 5, 0, 0));
		wait_drained();

		for (int n = 0; n < NODES; n++)
			add_item(make_item(CMD_LOAD, n, 1, 1, 0));
		add_item(make_item(CMD_SEARCH, 0, 255, 0, 0));
		add_item(make_item(CMD_READ, 0, 0, 0, 0));
		add_item(make_item(CMD_SEARCH, 255, 0, 0, 0));
		add_item(make_item(CMD_READ, 254, 0, 0, 0));
		queue_random(30);
		wait_drained();

		hold_sender = 1'b1;
		queue_random(10);
		repeat (50) @(posedge clk);
		hold_sender = 1'b0;

		send_idle_pct = 73;
		queue_random(40);
		wait_drained();
		recv_stall_pct = 73;
		send_idle_pct = 0;
		queue_random(40);
		wait_drained();
		send_idle_pct = 25;
		recv_stall_pct = 25;
		queue_random(40);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(10);
		wait_drained();
		repeat (100) @(posedge clk);

		if (error_count == 0)
			$display("grid_graph_dfs_path_finder_unit regression: pass");
		else
			$display("grid_graph_dfs_path_finder_unit regression: fail");
		$finish;
	end

	initial begin
		#200ms;
		$display("grid_graph_dfs_path_finder_unit regression: fail");
		$finish;
	end
endmodule
